>>> hdl/lpad_pkg.sv
package lpad_pkg;

  localparam int unsigned MAX_FILES  = 32;
  localparam int unsigned NAME_LIMIT = 64;

  localparam int unsigned FILES_W = $clog2(MAX_FILES + 1);
  localparam int unsigned NLEN_W  = $clog2(NAME_LIMIT);
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned OLEN_W  = 6;

  // result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_ENTRY   = 3'd1,
    KIND_END     = 3'd2,
    KIND_BADLEN  = 3'd3,
    KIND_OVERRUN = 3'd4,
    KIND_TRUNC   = 3'd5,
    KIND_EXHAUST = 3'd6,
    KIND_FULL    = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_NAME = 3'd1,
    PH_SIZE = 3'd2,
    PH_DATA = 3'd3,
    PH_DONE = 3'd4
  } phase_e;

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        addr;
    logic [31:0]        size;
    logic [OLEN_W-1:0]  nlen;
    logic [7:0]         ch;
    logic               last;
  } res_t;

endpackage

>>> hdl/length_prefixed_archive_deframer.sv
// Archive deframer: takes one archive byte per beat and parses records of
// {name length (4 B LE), name, data size (4 B LE), data}. A byte is parsed in
// the cycle it is accepted, so the input runs at one byte per cycle while the
// queue has room. A byte gives zero, one or two results (a name byte plus
// truncation, or a file entry plus exhausted/table full); results are written
// into a 4-entry result queue and leave at one per output beat. The input
// takes a byte whenever at least two queue slots are free. A two-result byte
// always ends the parse, so with the output always ready the queue never holds
// more than two results and the input never stalls. Write
// archive_base/archive_size only while idle; parsing is not restarted by a
// write, only by reset.
module length_prefixed_archive_deframer
  import lpad_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [31:0]         cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          byte_value_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          kind_o,
  output logic [IDX_W-1:0]    file_index_o,
  output logic [31:0]         data_address_o,
  output logic [31:0]         data_size_o,
  output logic [OLEN_W-1:0]   name_length_o,
  output logic [7:0]          name_char_o,
  output logic                last_of_run_o
);

  logic [31:0]        base_q, size_q;
  logic [31:0]        pos_q, pos_d;
  phase_e             phase_q, phase_d;
  logic [31:0]        hdr_q, hdr_d;
  logic [1:0]         hcnt_q, hcnt_d;
  logic [31:0]        rem_q, rem_d;
  logic [NLEN_W-1:0]  nlen_q, nlen_d;
  logic [FILES_W-1:0] files_q, files_d;

  res_t               queue_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;

  logic               in_acc, out_acc, active, at_end;
  logic [31:0]        rem_arch, hdr_v, rem_dec;
  logic               first_en, term_en;
  res_t               first_res, term_res, r0, r1;
  logic [1:0]         n_res;

  assign in_ready_o = cnt_q <= QCNT_W'(QDEPTH - 2);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_valid_o = cnt_q != '0;
  assign out_acc    = out_valid_o && out_ready_i;

  assign active = (phase_q != PH_DONE) && (base_q != '0) && (size_q != '0) &&
                  (pos_q < size_q);
  // bytes left including this one; at least 1 while active
  assign rem_arch = size_q - pos_q;
  assign at_end   = rem_arch == 32'd1;
  assign hdr_v    = hdr_q | (32'(byte_value_i) << {hcnt_q, 3'b000});
  assign rem_dec  = (rem_q != '0) ? rem_q - 32'd1 : rem_q;

  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    hdr_d     = hdr_q;
    hcnt_d    = hcnt_q;
    rem_d     = rem_q;
    nlen_d    = nlen_q;
    files_d   = files_q;
    first_en  = 1'b0;
    term_en   = 1'b0;
    first_res = '0;
    term_res  = '0;

    if (in_acc && active) begin
      pos_d = pos_q + 32'd1;
      unique case (phase_q) inside
        PH_LEN, PH_SIZE: begin
          if (hcnt_q != 2'd3) begin
            hcnt_d = hcnt_q + 2'd1;
            hdr_d  = hdr_v;
            if (at_end) begin
              term_en       = 1'b1;
              term_res.kind = KIND_TRUNC;
            end
          end else begin
            hcnt_d = '0;
            hdr_d  = '0;
            if (phase_q == PH_LEN) begin
              if (hdr_v == '0) begin
                term_en       = 1'b1;
                term_res.kind = KIND_END;
              end else if (hdr_v >= 32'(NAME_LIMIT)) begin
                term_en       = 1'b1;
                term_res.kind = KIND_BADLEN;
              end else begin
                nlen_d  = hdr_v[NLEN_W-1:0];
                rem_d   = hdr_v;
                phase_d = PH_NAME;
                if (at_end) begin
                  term_en       = 1'b1;
                  term_res.kind = KIND_TRUNC;
                end
              end
            end else begin
              // size must fit in the bytes after this one
              if (hdr_v >= rem_arch) begin
                term_en       = 1'b1;
                term_res.kind = KIND_OVERRUN;
              end else begin
                first_en       = 1'b1;
                first_res.kind = KIND_ENTRY;
                first_res.idx  = IDX_W'(files_q);
                first_res.addr = base_q + pos_d;
                first_res.size = hdr_v;
                first_res.nlen = OLEN_W'(nlen_q);
                files_d        = files_q + FILES_W'(1);
                if (hdr_v == '0) begin
                  phase_d = PH_LEN;
                  if (at_end) begin
                    term_en       = 1'b1;
                    term_res.kind = KIND_EXHAUST;
                  end else if (files_d >= FILES_W'(MAX_FILES)) begin
                    term_en       = 1'b1;
                    term_res.kind = KIND_FULL;
                  end
                end else begin
                  rem_d   = hdr_v;
                  phase_d = PH_DATA;
                end
              end
            end
          end
        end
        PH_NAME: begin
          first_en       = 1'b1;
          first_res.kind = KIND_NAME;
          first_res.idx  = IDX_W'(files_q);
          first_res.ch   = byte_value_i;
          rem_d          = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_SIZE;
          end
          if (at_end) begin
            term_en       = 1'b1;
            term_res.kind = KIND_TRUNC;
          end
        end
        PH_DATA: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_LEN;
            if (at_end) begin
              term_en       = 1'b1;
              term_res.kind = KIND_EXHAUST;
            end else if (files_q >= FILES_W'(MAX_FILES)) begin
              term_en       = 1'b1;
              term_res.kind = KIND_FULL;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
      if (term_en) begin
        phase_d      = PH_DONE;
        term_res.idx = IDX_W'(files_d);
      end
    end
  end

  // pack up to two results; the final one carries last
  always_comb begin
    n_res = {1'b0, first_en} + {1'b0, term_en};
    r0    = first_en ? first_res : term_res;
    r1    = term_res;
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      size_q  <= '0;
      pos_q   <= '0;
      phase_q <= PH_LEN;
      hdr_q   <= '0;
      hcnt_q  <= '0;
      rem_q   <= '0;
      nlen_q  <= '0;
      files_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_BASE: base_q <= cfg_data_i;
          REG_SIZE: size_q <= cfg_data_i;
        endcase
      end
      pos_q   <= pos_d;
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      hcnt_q  <= hcnt_d;
      rem_q   <= rem_d;
      nlen_q  <= nlen_d;
      files_q <= files_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(n_res);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(n_res) - QCNT_W'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= r0;
    end
    if (n_res == 2'd2) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= r1;
    end
  end

  assign kind_o         = queue_q[rd_ptr_q].kind;
  assign file_index_o   = queue_q[rd_ptr_q].idx;
  assign data_address_o = queue_q[rd_ptr_q].addr;
  assign data_size_o    = queue_q[rd_ptr_q].size;
  assign name_length_o  = queue_q[rd_ptr_q].nlen;
  assign name_char_o    = queue_q[rd_ptr_q].ch;
  assign last_of_run_o  = queue_q[rd_ptr_q].last;

endmodule

>>> hdl/lpad_chk.sv
module lpad_chk
  import lpad_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         kind_o,
  input logic [31:0]        data_address_o,
  input logic [31:0]        data_size_o,
  input logic [OLEN_W-1:0]  name_length_o,
  input logic               last_of_run_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(data_size_o) && $stable(last_of_run_o))
    else $error("result beat changed while stalled");

  // entry fields are zero on every other kind
  a_non_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_ENTRY |->
    data_address_o == '0 && data_size_o == '0 && name_length_o == '0)
    else $error("entry fields set on non-entry result");

  // terminal results always close the run of their byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_NAME && kind_o != KIND_ENTRY |-> last_of_run_o)
    else $error("terminal result without last flag");

  // an entry always follows a nonempty name
  a_entry_nlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ENTRY |-> name_length_o != '0)
    else $error("file entry with zero name length");

endmodule

bind length_prefixed_archive_deframer lpad_chk u_lpad_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .data_address_o (data_address_o),
  .data_size_o    (data_size_o),
  .name_length_o  (name_length_o),
  .last_of_run_o  (last_of_run_o)
);

>>> dv/lpad_parse_checker.sv
`timescale 1ns / 100ps

// Watches the register port and both channels, keeps its own copy of the
// parser state and compares every output beat with the oldest result due.
module lpad_parse_checker
  import lpad_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [31:0]       cfg_data_i,

  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        byte_value_i,

  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [2:0]        kind_i,
  input  logic [IDX_W-1:0]  file_index_i,
  input  logic [31:0]       data_address_i,
  input  logic [31:0]       data_size_i,
  input  logic [OLEN_W-1:0] name_length_i,
  input  logic [7:0]        name_char_i,
  input  logic              last_of_run_i,

  output int                fail_count_o,
  output int                pending_o
);

  localparam logic [1:0] HDR_LAST = 2'd3;

  logic [31:0]        arch_base;
  logic [31:0]        arch_size;

  logic [31:0]        pos;
  phase_e             ph;
  logic [31:0]        hdr_acc;
  logic [1:0]         hdr_cnt;
  logic [31:0]        remaining;
  logic [OLEN_W-1:0]  cur_nlen;
  logic [FILES_W-1:0] files;

  res_t               due_results[$];
  res_t               want;
  int                 fail_count;

  assign fail_count_o = fail_count;

  task automatic add_result(input kind_e k, input logic [IDX_W-1:0] i,
                            input logic [31:0] a, input logic [31:0] s,
                            input logic [OLEN_W-1:0] n, input logic [7:0] c);
    res_t r;
    r.kind = k;
    r.idx  = i;
    r.addr = a;
    r.size = s;
    r.nlen = n;
    r.ch   = c;
    r.last = 1'b0;
    due_results.push_back(r);
  endtask

  task automatic finish_run(input kind_e k);
    ph = PH_DONE;
    add_result(k, IDX_W'(files), 32'd0, 32'd0, '0, 8'd0);
  endtask

  task automatic close_record(input logic at_end);
    ph = PH_LEN;
    if (at_end) begin
      finish_run(KIND_EXHAUST);
    end else if (files >= MAX_FILES) begin
      finish_run(KIND_FULL);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int          queued;
    logic [31:0] v;
    logic        at_end;
    queued = due_results.size();
    if (ph == PH_DONE || arch_base == 0 || arch_size == 0 || pos >= arch_size) begin
      return;
    end
    pos    = pos + 32'd1;
    at_end = (pos == arch_size);
    case (ph) inside
      PH_LEN, PH_SIZE: begin
        hdr_acc = hdr_acc | ({24'd0, b} << (8 * hdr_cnt));
        if (hdr_cnt != HDR_LAST) begin
          hdr_cnt = hdr_cnt + 2'd1;
          if (at_end) finish_run(KIND_TRUNC);
        end else begin
          v       = hdr_acc;
          hdr_acc = '0;
          hdr_cnt = '0;
          if (ph == PH_LEN) begin
            if (v == 0) begin
              finish_run(KIND_END);
            end else if (v >= NAME_LIMIT) begin
              finish_run(KIND_BADLEN);
            end else begin
              cur_nlen  = v[OLEN_W-1:0];
              remaining = v;
              ph        = PH_NAME;
              if (at_end) finish_run(KIND_TRUNC);
            end
          end else begin
            if (v > arch_size - pos) begin
              finish_run(KIND_OVERRUN);
            end else begin
              add_result(KIND_ENTRY, IDX_W'(files), arch_base + pos, v, cur_nlen, 8'd0);
              files = files + FILES_W'(1);
              if (v == 0) begin
                close_record(at_end);
              end else begin
                remaining = v;
                ph        = PH_DATA;
              end
            end
          end
        end
      end
      PH_NAME: begin
        add_result(KIND_NAME, IDX_W'(files), 32'd0, 32'd0, '0, b);
        if (remaining > 0) remaining = remaining - 32'd1;
        if (remaining == 0) ph = PH_SIZE;
        if (at_end) finish_run(KIND_TRUNC);
      end
      default: begin
        if (remaining > 0) remaining = remaining - 32'd1;
        if (remaining == 0) close_record(at_end);
      end
    endcase
    if (due_results.size() > queued) begin
      due_results[due_results.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string label, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, exp_val,
               act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_base  = '0;
      arch_size  = '0;
      pos        = '0;
      ph         = PH_LEN;
      hdr_acc    = '0;
      hdr_cnt    = '0;
      remaining  = '0;
      cur_nlen   = '0;
      files      = '0;
      fail_count = 0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_BASE) arch_base = cfg_data_i;
        else arch_size = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) parse_byte(byte_value_i);
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d", $time,
                   kind_i);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_i));
          check_field("file_index", 32'(want.idx), 32'(file_index_i));
          check_field("data_address", want.addr, data_address_i);
          check_field("data_size", want.size, data_size_i);
          check_field("name_length", 32'(want.nlen), 32'(name_length_i));
          check_field("name_char", 32'(want.ch), 32'(name_char_i));
          check_field("last_of_run", 32'(want.last), 32'(last_of_run_i));
        end
      end
      pending_o <= due_results.size();
    end
  end

endmodule

>>> dv/length_prefixed_archive_deframer_test.sv
`timescale 1ns / 100ps

module length_prefixed_archive_deframer_test;
  import lpad_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;

  // how the archive is brought to its end
  typedef enum int {
    FIN_END_MARK,
    FIN_BADLEN,
    FIN_OVERRUN,
    FIN_TRUNC,
    FIN_EXHAUST,
    FIN_FULL,
    FIN_OPEN
  } finish_e;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic              cfg_addr_i   = REG_BASE;
  logic [31:0]       cfg_data_i   = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [7:0]        byte_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [2:0]        kind_o;
  logic [IDX_W-1:0]  file_index_o;
  logic [31:0]       data_address_o;
  logic [31:0]       data_size_o;
  logic [OLEN_W-1:0] name_length_o;
  logic [7:0]        name_char_o;
  logic              last_of_run_o;

  int                fail_count;
  int                pending;

  bit                calm;
  bit                hold_long;
  bit                live;
  int unsigned       arch_pos;
  logic [31:0]       cur_base;

  length_prefixed_archive_deframer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .file_index_o   (file_index_o),
    .data_address_o (data_address_o),
    .data_size_o    (data_size_o),
    .name_length_o  (name_length_o),
    .name_char_o    (name_char_o),
    .last_of_run_o  (last_of_run_o)
  );

  lpad_parse_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_i         (kind_o),
    .file_index_i   (file_index_o),
    .data_address_i (data_address_o),
    .data_size_i    (data_size_o),
    .name_length_i  (name_length_o),
    .name_char_i    (name_char_o),
    .last_of_run_i  (last_of_run_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("length_prefixed_archive_deframer_test: FAIL");
    $finish;
  end

  // result side: a random stall before each beat (none while calm), plus one long hold-off on request
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_long && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [31:0] rand_base();
    logic [31:0] v;
    v = $urandom;
    if (v == 0) v = 32'h1;
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] v);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    if (live) arch_pos++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic send_head(input int unsigned nlen, input logic [31:0] dsize);
    send_word(nlen);
    repeat (nlen) send_byte(8'($urandom));
    send_word(dsize);
  endtask

  task automatic send_record(input int unsigned nlen, input int unsigned dsize);
    send_head(nlen, dsize);
    send_noise(dsize);
  endtask

  // stop offering bytes until every due result has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [31:0] base, input logic [31:0] arch_len);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= REG_BASE;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_addr_i <= REG_SIZE;
    cfg_data_i <= arch_len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_base = base;
  endtask

  initial begin
    finish_e     fin;
    int unsigned nrec;
    int unsigned nlen;
    int unsigned dsize;
    int unsigned cut;
    logic [31:0] big;

    calm      = 1'b0;
    hold_long = 1'b0;
    live      = 1'b0;
    arch_pos  = 0;
    cur_base  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no archive: both registers zero, then each one zero on its own
    send_noise(3);
    set_regs(32'h0, 32'hFFFF_FFFF);
    send_noise(3);
    set_regs(32'h1234_5678, 32'h0);
    send_noise(3);

    // base near the top so data addresses wrap
    set_regs(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    live = 1'b1;
    send_word(32'd1);
    send_byte(8'hFF);
    send_word(32'd0);
    send_word(32'd2);
    send_byte(8'h00);
    send_byte(8'h80);
    send_word(32'd3);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h55);

    // archive end at or below the current position: bytes are dropped
    set_regs(cur_base, arch_pos - $urandom_range(0, 5));
    live = 1'b0;
    send_noise(4);
    set_regs(32'h0000_0001, 32'hFFFF_FFFF);
    live = 1'b1;

    fin  = finish_e'($urandom_range(0, 6));
    nrec = (fin == FIN_FULL) ? 30 : $urandom_range(24, 29);

    for (int unsigned r = 0; r < nrec; r++) begin
      calm = (r % 6 == 5);
      if (r == 8) hold_long = 1'b1;
      if (r % 7 == 3) begin
        set_regs(32'h0, 32'hFFFF_FFFF);
        live = 1'b0;
        send_noise($urandom_range(2, 6));
        set_regs((r == 17) ? 32'hFFFF_FFFF : rand_base(), 32'hFFFF_FFFF);
        live = 1'b1;
      end
      nlen  = ($urandom_range(0, 9) == 0) ? NAME_LIMIT - 1 : $urandom_range(1, 40);
      dsize = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 16);
      if (r == 12) begin
        // base changes between the name and the size header
        send_word(nlen);
        send_noise(nlen);
        set_regs(rand_base(), 32'hFFFF_FFFF);
        send_word(dsize);
        send_noise(dsize);
      end else begin
        send_record(nlen, dsize);
      end
    end
    calm = 1'b0;

    nlen  = $urandom_range(1, 20);
    dsize = $urandom_range(0, 8);
    case (fin)
      FIN_END_MARK: send_word(32'd0);
      FIN_BADLEN: begin
        big = $urandom_range(0, 1) ? NAME_LIMIT : ($urandom | NAME_LIMIT);
        send_word(big);
      end
      FIN_OVERRUN: begin
        if ($urandom_range(0, 1)) begin
          send_head(nlen, 32'hFFFF_FFFF);
        end else begin
          cut = $urandom_range(0, 20);
          set_regs(cur_base, arch_pos + 8 + nlen + cut);
          send_head(nlen, cut + $urandom_range(1, 100));
        end
      end
      FIN_TRUNC: begin
        // end inside a header, inside the name or just after it
        set_regs(cur_base, arch_pos + $urandom_range(1, nlen + 7));
        send_record(nlen, dsize);
      end
      FIN_EXHAUST: begin
        set_regs(cur_base, arch_pos + 8 + nlen + dsize);
        send_record(nlen, dsize);
      end
      FIN_FULL: ;
      default: begin
        // huge entry left open; archive then ends inside the data
        send_head(nlen, $urandom_range(32'h8000_0000, 32'hFFFF_0000));
        send_noise(20);
        set_regs(cur_base, arch_pos + 3);
      end
    endcase
    live = 1'b0;
    send_noise(10);

    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("length_prefixed_archive_deframer_test: PASS");
    end else begin
      $display("length_prefixed_archive_deframer_test: FAIL");
    end
    $finish;
  end

endmodule
